// ----- rtl/core/rstc_pkg.sv -----
// Package for the remote service TTL cache: opcodes, status codes, FSM states.
// No dependencies.
package rstc_pkg;

  typedef enum logic [2:0] {
    OP_LEARN  = 3'd0,
    OP_FORGET = 3'd1,
    OP_FNODE  = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_EXPIRE = 3'd4,
    OP_COUNT  = 3'd5
  } op_e;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TOOK     = 3'd4;
  localparam logic [2:0] ST_NOTOWNER = 3'd5;

  localparam logic [1:0] H_FRESH   = 2'd0;
  localparam logic [1:0] H_STALE   = 2'd1;
  localparam logic [1:0] H_EXPIRED = 2'd2;

  localparam logic [0:0] CFG_HEARTBEAT = 1'b0;
  localparam logic [0:0] CFG_TTL       = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_WRITE = 2'd2,
    S_OUT  = 2'd3
  } state_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  health;
    logic [31:0] node_out;
    logic [31:0] partition_out;
    logic [7:0]  kind_out;
    logic [31:0] port_out;
    logic [1:0]  serving_out;
    logic [5:0]  count;
  } result_t;

  typedef struct packed {
    logic [2:0]   op;
    logic [255:0] name;
    logic [31:0]  node;
    logic [31:0]  partition;
    logic [7:0]   svc_kind;
    logic [31:0]  svc_port;
    logic [1:0]   serving_in;
    logic [63:0]  now;
  } item_t;

  // entry record held in memory
  typedef struct packed {
    logic [255:0] name;
    logic [31:0]  node;
    logic [31:0]  partition;
    logic [7:0]   kind;
    logic [31:0]  port;
    logic [1:0]   serving;
    logic [63:0]  stamp;
  } entry_t;

endpackage

// ----- rtl/core/rstc_if.sv -----
// Valid/ready channel interfaces for the cache.
// Depends on rstc_pkg.
interface rstc_in_if;
  logic           valid;
  logic           ready;
  rstc_pkg::item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rstc_out_if;
  logic             valid;
  logic             ready;
  rstc_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/rstc_mem.sv -----
// Entry memory: one write port, one registered read port.
// Depends on rstc_pkg.
module rstc_mem #(
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  rstc_pkg::entry_t         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output rstc_pkg::entry_t         rdata_o
);
  rstc_pkg::entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/rstc_health.sv -----
// Health classification of an entry from its age against the two thresholds.
// Depends on rstc_pkg.
module rstc_health (
  input  logic [63:0] now_i,
  input  logic [63:0] stamp_i,
  input  logic [31:0] heartbeat_i,
  input  logic [31:0] ttl_i,
  output logic [1:0]  health_o
);
  logic [63:0] age;
  logic [63:0] stale_lim;

  always_comb begin
    age       = (now_i > stamp_i) ? (now_i - stamp_i) : 64'd0;
    stale_lim = {31'd0, heartbeat_i, 1'b0};
    if (age >= {32'd0, ttl_i}) begin
      health_o = rstc_pkg::H_EXPIRED;
    end else if (age >= stale_lim) begin
      health_o = rstc_pkg::H_STALE;
    end else begin
      health_o = rstc_pkg::H_FRESH;
    end
  end
endmodule

// ----- rtl/core/remote_service_ttl_cache.sv -----
// Remote service TTL cache: a keyed cache of announced services with ageing.
// Usage: one input item enters on in_ch (valid/ready) and produces one result
// on out_ch. Each operation walks the entry memory one slot per cycle, one
// entry fetched per cycle from the registered read port: a scan state over
// every slot, a write-back state, then an output state that raises the
// result register. The next item is taken only once the previous one has
// brought the block back to idle.
// Items are handled one at a time; in_ch.ready is high only while idle.
// The result waits in an output register until taken; while out_ch stalls
// the next item is still accepted and scanned, then holds in write-back.
// Reset clears all valid bits (held in flip-flops) and restores the
// heartbeat (500) and TTL (1500) registers; entry contents stay undefined
// until written, and are only read for valid slots, so no clearing pass.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0
// heartbeat, 1 TTL); the user must issue writes only while idle, unchecked.
// Names: bytes after the first zero byte, and byte NAME_BYTES-1 on up, are
// masked before compare and store.
module remote_service_ttl_cache #(
  parameter int unsigned ENTRIES    = 32,
  parameter int unsigned NAME_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  rstc_in_if.sink     in_ch,
  rstc_out_if.source  out_ch
);
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1) + 1;

  rstc_pkg::state_e state_q, state_d;
  logic [31:0] hb_q, ttl_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  rstc_pkg::item_t item_q, item_d;
  logic [CW-1:0] idx_q, idx_d;     // read address counter
  logic [AW-1:0] raddr;
  logic          rd_vld_q;          // a read is returning this cycle
  logic [AW-1:0] rd_idx_q;
  logic          hit_q, hit_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  rstc_pkg::entry_t hit_ent_q, hit_ent_d;
  logic          free_q, free_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic [5:0]    cnt_q, cnt_d;
  rstc_pkg::result_t res_q, res_d;
  logic          out_vld_q, out_vld_d;
  rstc_pkg::entry_t rdata, wdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [1:0]    rd_health, hit_health;
  logic [255:0]  cname;

  // canonical name: keep bytes up to the first zero, below NAME_BYTES-1
  always_comb begin
    logic run;
    cname = '0;
    run = 1'b1;
    for (int b = 0; b < 32; b++) begin
      if (b < NAME_BYTES - 1 && run && in_ch.payload.name[b*8 +: 8] != 8'd0) begin
        cname[b*8 +: 8] = in_ch.payload.name[b*8 +: 8];
      end else begin
        run = 1'b0;
      end
    end
  end

  assign raddr = idx_q[AW-1:0];

  rstc_mem #(.Depth(ENTRIES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rstc_health u_hrd (
    .now_i(item_q.now), .stamp_i(rdata.stamp),
    .heartbeat_i(hb_q), .ttl_i(ttl_q), .health_o(rd_health)
  );
  rstc_health u_hhit (
    .now_i(item_q.now), .stamp_i(hit_ent_q.stamp),
    .heartbeat_i(hb_q), .ttl_i(ttl_q), .health_o(hit_health)
  );

  assign in_ch.ready    = (state_q == rstc_pkg::S_IDLE);
  assign out_ch.valid   = out_vld_q;
  assign out_ch.payload = res_q;

  always_comb begin
    logic slot_v;
    state_d    = state_q;
    valid_d    = valid_q;
    item_d     = item_q;
    idx_d      = idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_ent_d  = hit_ent_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q;
    we         = 1'b0;
    waddr      = hit_idx_q;
    wdata      = '0;
    slot_v     = valid_q[rd_idx_q];
    if (out_ch.valid && out_ch.ready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      rstc_pkg::S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          item_d      = in_ch.payload;
          item_d.name = cname;
          idx_d       = '0;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          cnt_d       = '0;
          state_d     = rstc_pkg::S_SCAN;
        end
      end
      rstc_pkg::S_SCAN: begin
        if (idx_q < CW'(ENTRIES)) begin
          idx_d = idx_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (!slot_v && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (slot_v && rdata.name == item_q.name && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
            hit_ent_d = rdata;
          end
          case (item_q.op)
            rstc_pkg::OP_FNODE: begin
              if (slot_v && rdata.node == item_q.node) begin
                valid_d[rd_idx_q] = 1'b0;
                cnt_d = cnt_q + 1'b1;
              end
            end
            rstc_pkg::OP_EXPIRE: begin
              if (slot_v && rd_health == rstc_pkg::H_EXPIRED) begin
                valid_d[rd_idx_q] = 1'b0;
                cnt_d = cnt_q + 1'b1;
              end
            end
            rstc_pkg::OP_COUNT: begin
              if (slot_v) cnt_d = cnt_q + 1'b1;
            end
            default: ;
          endcase
          if (rd_idx_q == AW'(ENTRIES - 1)) state_d = rstc_pkg::S_WRITE;
        end
      end
      rstc_pkg::S_WRITE: begin
        // hold here while an earlier result still waits on out_ch
        if (!out_vld_q || out_ch.ready) begin
          res_d = '0;
          res_d.count = cnt_q;
          case (item_q.op)
            rstc_pkg::OP_LEARN: begin
              wdata.name      = item_q.name;
              wdata.node      = item_q.node;
              wdata.partition = item_q.partition;
              wdata.kind      = item_q.svc_kind;
              wdata.port      = item_q.svc_port;
              wdata.serving   = item_q.serving_in;
              wdata.stamp     = item_q.now;
              if (item_q.name[63:0] == 64'd0 || item_q.node == 32'd0) begin
                res_d.status = rstc_pkg::ST_INVALID;
              end else if (hit_q) begin
                we = 1'b1;
                if (hit_ent_q.node != item_q.node) res_d.status = rstc_pkg::ST_TOOK;
              end else if (free_q) begin
                we = 1'b1;
                waddr = free_idx_q;
                valid_d[free_idx_q] = 1'b1;
              end else begin
                res_d.status = rstc_pkg::ST_FULL;
              end
            end
            rstc_pkg::OP_FORGET: begin
              if (!hit_q) res_d.status = rstc_pkg::ST_NOTFOUND;
              else if (hit_ent_q.node != item_q.node) res_d.status = rstc_pkg::ST_NOTOWNER;
              else valid_d[hit_idx_q] = 1'b0;
            end
            rstc_pkg::OP_LOOKUP: begin
              res_d.status = rstc_pkg::ST_NOTFOUND;
              res_d.health = rstc_pkg::H_EXPIRED;
              if (hit_q && hit_health != rstc_pkg::H_EXPIRED) begin
                res_d.status        = rstc_pkg::ST_OK;
                res_d.health        = hit_health;
                res_d.node_out      = hit_ent_q.node;
                res_d.partition_out = hit_ent_q.partition;
                res_d.kind_out      = hit_ent_q.kind;
                res_d.port_out      = hit_ent_q.port;
                res_d.serving_out   = hit_ent_q.serving;
              end
            end
            rstc_pkg::OP_FNODE, rstc_pkg::OP_EXPIRE, rstc_pkg::OP_COUNT: ;
            default: res_d.status = rstc_pkg::ST_INVALID;
          endcase
          state_d = rstc_pkg::S_OUT;
        end
      end
      rstc_pkg::S_OUT: begin
        out_vld_d = 1'b1;
        state_d   = rstc_pkg::S_IDLE;
      end
      default: state_d = rstc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rstc_pkg::S_IDLE;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      hb_q      <= 32'd500;
      ttl_q     <= 32'd1500;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      out_vld_q <= out_vld_d;
      rd_vld_q  <= (state_q == rstc_pkg::S_SCAN) && (idx_q < CW'(ENTRIES));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rstc_pkg::CFG_HEARTBEAT: hb_q <= cfg_data_i;
          rstc_pkg::CFG_TTL:       ttl_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    idx_q      <= idx_d;
    rd_idx_q   <= raddr;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_ent_q  <= hit_ent_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
  end

`ifndef SYNTHESIS
  // results only appear after the write-back step
  a_out_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == rstc_pkg::S_OUT) else $error("stray result");
  // write-back waits while the previous result is still held
  a_write_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rstc_pkg::S_WRITE && out_vld_q && !out_ch.ready)
      |=> state_q == rstc_pkg::S_WRITE) else $error("result overwritten");
  // a pending result holds until transferred
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ch.ready) |=> (out_vld_q && $stable(res_q))) else $error("result lost");
`endif
endmodule

// ----- dv/remote_service_ttl_cache_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for remote_service_ttl_cache: directed table then random ops.
// Depends on rstc_pkg, the rstc_in_if / rstc_out_if interfaces and the cache RTL.
module remote_service_ttl_cache_test;

  localparam int unsigned SLOTS    = 32;
  localparam int unsigned POOL     = 44;   // more names than slots, so the cache fills
  localparam int unsigned N_RANDOM = 1430;
  localparam int unsigned DRAIN    = 40;   // longer than one item takes to pass through the block
  // opcodes the block does not define
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  rstc_in_if  in_ch ();
  rstc_out_if out_ch ();

  remote_service_ttl_cache dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache: valid bits, entries and both thresholds.
  // ---------------------------------------------------------------------------
  logic         sh_valid [SLOTS];
  logic [255:0] sh_name  [SLOTS];
  logic [31:0]  sh_node  [SLOTS];
  logic [31:0]  sh_part  [SLOTS];
  logic [7:0]   sh_kind  [SLOTS];
  logic [31:0]  sh_port  [SLOTS];
  logic [1:0]   sh_serv  [SLOTS];
  logic [63:0]  sh_stamp [SLOTS];
  logic [31:0]  sh_heartbeat;
  logic [31:0]  sh_ttl;

  rstc_pkg::result_t pending_results [$];   // results owed by the block, oldest first
  int      n_fail;
  int      n_items;
  int      n_checked;
  int      n_full;
  int      n_took;
  int      n_stale;
  int      sender_idle_pct;
  int      recv_stall_pct;

  // Name as the block keys it: bytes 0..30 up to the first zero byte.
  function automatic logic [255:0] key_of(logic [255:0] raw);
    logic [255:0] k;
    k = '0;
    for (int i = 0; i < 31; i++) begin
      if (raw[8*i +: 8] == 8'h00) break;
      k[8*i +: 8] = raw[8*i +: 8];
    end
    return k;
  endfunction

  function automatic int slot_of(logic [255:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && sh_name[i] == k) return i;
    return -1;
  endfunction

  // Age saturates at zero when the clock seems to run backwards.
  function automatic logic [1:0] age_class(logic [63:0] now, logic [63:0] stamp);
    logic [63:0] age;
    age = (now > stamp) ? now - stamp : 64'd0;
    if (age >= {32'd0, sh_ttl}) return rstc_pkg::H_EXPIRED;
    if (age >= {31'd0, sh_heartbeat, 1'b0}) return rstc_pkg::H_STALE;
    return rstc_pkg::H_FRESH;
  endfunction

  // Applies one operation to the shadow cache and returns the result it owes.
  function automatic rstc_pkg::result_t apply_op(rstc_pkg::item_t it);
    rstc_pkg::result_t r;
    logic [255:0]      k;
    int                e;
    logic [1:0]        h;
    r = '0;
    k = key_of(it.name);
    e = slot_of(k);
    case (it.op)
      rstc_pkg::OP_LEARN: begin
        if (k == '0 || it.node == 32'd0) begin
          r.status = rstc_pkg::ST_INVALID;
        end else begin
          if (e >= 0) begin
            if (sh_node[e] != it.node) r.status = rstc_pkg::ST_TOOK;
          end else begin
            for (int i = 0; i < SLOTS; i++)
              if (!sh_valid[i]) begin e = i; break; end
            if (e < 0) r.status = rstc_pkg::ST_FULL;
            else begin
              sh_valid[e] = 1'b1;
              sh_name[e]  = k;
            end
          end
          if (e >= 0) begin
            sh_node[e]  = it.node;
            sh_part[e]  = it.partition;
            sh_kind[e]  = it.svc_kind;
            sh_port[e]  = it.svc_port;
            sh_serv[e]  = it.serving_in;
            sh_stamp[e] = it.now;
          end
        end
      end
      rstc_pkg::OP_FORGET: begin
        if (e < 0) r.status = rstc_pkg::ST_NOTFOUND;
        else if (sh_node[e] != it.node) r.status = rstc_pkg::ST_NOTOWNER;
        else sh_valid[e] = 1'b0;
      end
      rstc_pkg::OP_FNODE: begin
        for (int i = 0; i < SLOTS; i++)
          if (sh_valid[i] && sh_node[i] == it.node) begin
            sh_valid[i] = 1'b0;
            r.count++;
          end
      end
      rstc_pkg::OP_LOOKUP: begin
        r.status = rstc_pkg::ST_NOTFOUND;
        r.health = rstc_pkg::H_EXPIRED;
        if (e >= 0) begin
          h = age_class(it.now, sh_stamp[e]);
          if (h != rstc_pkg::H_EXPIRED) begin
            r.status        = rstc_pkg::ST_OK;
            r.health        = h;
            r.node_out      = sh_node[e];
            r.partition_out = sh_part[e];
            r.kind_out      = sh_kind[e];
            r.port_out      = sh_port[e];
            r.serving_out   = sh_serv[e];
          end
        end
      end
      rstc_pkg::OP_EXPIRE: begin
        for (int i = 0; i < SLOTS; i++)
          if (sh_valid[i] && age_class(it.now, sh_stamp[i]) == rstc_pkg::H_EXPIRED) begin
            sh_valid[i] = 1'b0;
            r.count++;
          end
      end
      rstc_pkg::OP_COUNT: begin
        for (int i = 0; i < SLOTS; i++)
          if (sh_valid[i]) r.count++;
      end
      default: r.status = rstc_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side. Inputs move on the falling edge; acceptance is seen at the
  // rising edge where valid and ready are both high.
  // ---------------------------------------------------------------------------
  task automatic send_op(rstc_pkg::item_t it, logic typed, rstc_pkg::result_t typed_res);
    int                gap;
    rstc_pkg::result_t r;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    r = apply_op(it);
    if (r.status == rstc_pkg::ST_FULL) n_full++;
    if (r.status == rstc_pkg::ST_TOOK) n_took++;
    if (it.op == rstc_pkg::OP_LOOKUP && r.health == rstc_pkg::H_STALE) n_stale++;
    pending_results.push_back(typed ? typed_res : r);
    n_items++;
  endtask

  // Register writes only with the block idle: nothing owed, input quiet, and
  // long enough for an item with no result still in flight to finish.
  task automatic write_cfg(logic [0:0] idx, logic [31:0] val);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == rstc_pkg::CFG_HEARTBEAT) sh_heartbeat = val;
    else sh_ttl = val;
  endtask

  // Receiver: ready chosen afresh at each falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    rstc_pkg::result_t want;
    rstc_pkg::result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (pending_results.size() == 0) begin
        $error("result with nothing owed: %p", got);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); n_fail++;
        end
        if (got.health !== want.health) begin
          $error("health: expected %0d, got %0d", want.health, got.health); n_fail++;
        end
        if (got.node_out !== want.node_out) begin
          $error("node_out: expected %h, got %h", want.node_out, got.node_out); n_fail++;
        end
        if (got.partition_out !== want.partition_out) begin
          $error("partition_out: expected %h, got %h", want.partition_out,
                 got.partition_out); n_fail++;
        end
        if (got.kind_out !== want.kind_out) begin
          $error("kind_out: expected %h, got %h", want.kind_out, got.kind_out); n_fail++;
        end
        if (got.port_out !== want.port_out) begin
          $error("port_out: expected %h, got %h", want.port_out, got.port_out); n_fail++;
        end
        if (got.serving_out !== want.serving_out) begin
          $error("serving_out: expected %0d, got %0d", want.serving_out,
                 got.serving_out); n_fail++;
        end
        if (got.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, got.count); n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  logic [255:0] name_pool [POOL];
  int           name_len  [POOL];
  logic [63:0]  tick;

  function automatic logic [255:0] ascii_name(string s);
    logic [255:0] n;
    n = '0;
    for (int i = 0; i < s.len() && i < 32; i++) n[8*i +: 8] = s[i];
    return n;
  endfunction

  // A pool name, sometimes with junk behind its terminator or in byte 31,
  // which the block must ignore.
  function automatic logic [255:0] pick_name();
    int           p;
    logic [255:0] n;
    p = $urandom_range(POOL - 1);
    n = name_pool[p];
    if ($urandom_range(9) == 0 && name_len[p] < 30)
      for (int i = name_len[p] + 1; i < 32; i++) n[8*i +: 8] = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) n[255:248] = 8'($urandom_range(255));
    return n;
  endfunction

  function automatic logic [31:0] pick_node();
    case ($urandom_range(19))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      2:       return $urandom();
      default: return $urandom_range(1, 5);
    endcase
  endfunction

  function automatic logic [63:0] pick_now();
    case ($urandom_range(39))
      0: return {$urandom(), $urandom()};
      1: return 64'hffff_ffff_ffff_ffff;
      2: return 64'd0;
      3: return tick - $urandom_range(0, 2000);   // behind recent stamps
      default: begin
        tick = tick + $urandom_range(0, 300);
        return tick;
      end
    endcase
  endfunction

  function automatic rstc_pkg::item_t random_op();
    rstc_pkg::item_t it;
    int              r;
    it.name       = pick_name();
    it.node       = pick_node();
    it.partition  = $urandom();
    it.svc_kind   = 8'($urandom_range(255));
    it.svc_port   = $urandom();
    it.serving_in = 2'($urandom_range(3));
    it.now        = pick_now();
    r = $urandom_range(99);
    if (r < 40) it.op = rstc_pkg::OP_LEARN;
    else if (r < 68) it.op = rstc_pkg::OP_LOOKUP;
    else if (r < 80) it.op = rstc_pkg::OP_FORGET;
    else if (r < 85) it.op = rstc_pkg::OP_FNODE;
    else if (r < 92) it.op = rstc_pkg::OP_EXPIRE;
    else if (r < 97) it.op = rstc_pkg::OP_COUNT;
    else if (r < 98) it.op = OP_SPARE6;
    else if (r < 99) it.op = OP_SPARE7;
    else begin
      // pure noise across every field
      it.op   = 3'($urandom_range(7));
      it.name = {$urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()};
    end
    return it;
  endfunction

  // Directed table: one row per operation, expected result where obvious.
  typedef struct {
    rstc_pkg::item_t   it;
    logic              typed;
    rstc_pkg::result_t res;
  } step_row_t;

  step_row_t steps [$];

  function automatic rstc_pkg::item_t mk_op(logic [2:0] op, logic [255:0] nm,
                                            logic [31:0] node, logic [63:0] now);
    rstc_pkg::item_t it;
    it            = '0;
    it.op         = op;
    it.name       = nm;
    it.node       = node;
    it.partition  = 32'h0000_1234;
    it.svc_kind   = 8'h01;
    it.svc_port   = 32'd8080;
    it.serving_in = 2'd0;
    it.now        = now;
    return it;
  endfunction

  function automatic rstc_pkg::result_t st_only(logic [2:0] st, logic [1:0] h,
                                                logic [5:0] c);
    rstc_pkg::result_t r;
    r = '0;
    r.status = st;
    r.health = h;
    r.count  = c;
    return r;
  endfunction

  task automatic add_step(rstc_pkg::item_t it, logic typed, rstc_pkg::result_t res);
    step_row_t s;
    s.it    = it;
    s.typed = typed;
    s.res   = res;
    steps.push_back(s);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [255:0]      nm_a;
    logic [255:0]      nm_b;
    logic [255:0]      nm_max;
    rstc_pkg::item_t   it;
    rstc_pkg::result_t full_res;
    logic [31:0]       hb_set  [5];
    logic [31:0]       ttl_set [5];

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = rstc_pkg::CFG_HEARTBEAT;
    cfg_data_i      = '0;
    in_ch.valid     = 1'b0;
    in_ch.payload   = '0;
    out_ch.ready    = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    n_fail = 0; n_items = 0; n_checked = 0; n_full = 0; n_took = 0; n_stale = 0;
    sh_heartbeat = 32'd500;
    sh_ttl       = 32'd1500;
    tick         = 64'd1000;
    for (int i = 0; i < SLOTS; i++) sh_valid[i] = 1'b0;

    for (int p = 0; p < POOL; p++) begin
      name_len[p]  = (p % 8 == 0) ? 31 : $urandom_range(1, 12);
      name_pool[p] = '0;
      for (int i = 0; i < name_len[p]; i++)
        name_pool[p][8*i +: 8] = 8'($urandom_range(1, 255));
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    nm_a   = ascii_name("a");
    nm_b   = ascii_name("svc.b");
    nm_max = {256{1'b1}};           // byte 31 must be dropped from the key

    // reset state, absent names, invalid learns
    add_step(mk_op(rstc_pkg::OP_COUNT, '0, 32'd0, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_OK, rstc_pkg::H_FRESH, 6'd0));
    add_step(mk_op(rstc_pkg::OP_LOOKUP, nm_a, 32'd1, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_NOTFOUND, rstc_pkg::H_EXPIRED, 6'd0));
    add_step(mk_op(rstc_pkg::OP_LEARN, '0, 32'd1, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_INVALID, rstc_pkg::H_FRESH, 6'd0));
    add_step(mk_op(rstc_pkg::OP_LEARN, nm_a, 32'd0, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_INVALID, rstc_pkg::H_FRESH, 6'd0));
    add_step(mk_op(rstc_pkg::OP_LEARN, nm_a, 32'd1, 64'd1000), 1'b1,
             st_only(rstc_pkg::ST_OK, rstc_pkg::H_FRESH, 6'd0));
    // all-ones learn, then read it back
    it = mk_op(rstc_pkg::OP_LEARN, nm_max, 32'hffff_ffff, 64'd1000);
    it.partition = '1; it.svc_kind = '1; it.svc_port = '1; it.serving_in = 2'd3;
    add_step(it, 1'b1, st_only(rstc_pkg::ST_OK, rstc_pkg::H_FRESH, 6'd0));
    full_res = '0;
    full_res.node_out = '1; full_res.partition_out = '1; full_res.kind_out = '1;
    full_res.port_out = '1; full_res.serving_out = 2'd3;
    add_step(mk_op(rstc_pkg::OP_LOOKUP, nm_max, 32'd0, 64'd1000), 1'b1, full_res);
    // age boundaries at the reset thresholds (stale at 1000, expired at 1500)
    add_step(mk_op(rstc_pkg::OP_LOOKUP, nm_a, 32'd0, 64'd1999), 1'b0, '0);
    add_step(mk_op(rstc_pkg::OP_LOOKUP, nm_a, 32'd0, 64'd2000), 1'b0, '0);
    add_step(mk_op(rstc_pkg::OP_LOOKUP, nm_a, 32'd0, 64'd2499), 1'b0, '0);
    add_step(mk_op(rstc_pkg::OP_LOOKUP, nm_a, 32'd0, 64'd2500), 1'b1,
             st_only(rstc_pkg::ST_NOTFOUND, rstc_pkg::H_EXPIRED, 6'd0));
    // clock behind stamp
    add_step(mk_op(rstc_pkg::OP_LOOKUP, nm_a, 32'd0, 64'd0), 1'b0, '0);
    // expired entry is still matched by learn; other node takes it over
    add_step(mk_op(rstc_pkg::OP_LEARN, nm_a, 32'd2, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_TOOK, rstc_pkg::H_FRESH, 6'd0));
    add_step(mk_op(rstc_pkg::OP_FORGET, nm_a, 32'd1, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_NOTOWNER, rstc_pkg::H_FRESH, 6'd0));
    add_step(mk_op(rstc_pkg::OP_FORGET, nm_b, 32'd1, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_NOTFOUND, rstc_pkg::H_FRESH, 6'd0));
    add_step(mk_op(rstc_pkg::OP_FORGET, nm_a, 32'd2, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_OK, rstc_pkg::H_FRESH, 6'd0));
    add_step(mk_op(OP_SPARE6, nm_a, 32'd1, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_INVALID, rstc_pkg::H_FRESH, 6'd0));
    add_step(mk_op(OP_SPARE7, nm_a, 32'd1, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_INVALID, rstc_pkg::H_FRESH, 6'd0));
    add_step(mk_op(rstc_pkg::OP_FNODE, '0, 32'hffff_ffff, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_OK, rstc_pkg::H_FRESH, 6'd1));
    add_step(mk_op(rstc_pkg::OP_LEARN, nm_b, 32'd3, 64'd0), 1'b0, '0);
    add_step(mk_op(rstc_pkg::OP_EXPIRE, '0, 32'd0, 64'hffff_ffff_ffff_ffff), 1'b1,
             st_only(rstc_pkg::ST_OK, rstc_pkg::H_FRESH, 6'd1));
    add_step(mk_op(rstc_pkg::OP_COUNT, '0, 32'd0, 64'd0), 1'b1,
             st_only(rstc_pkg::ST_OK, rstc_pkg::H_FRESH, 6'd0));

    foreach (steps[i]) send_op(steps[i].it, steps[i].typed, steps[i].res);

    // Random phases: thresholds from both extremes; phases 0 and 4 share an idling mix.
    hb_set[0] = 32'd500;        ttl_set[0] = 32'd1500;
    hb_set[1] = 32'd1;          ttl_set[1] = 32'd1;
    hb_set[2] = 32'hffff_ffff;  ttl_set[2] = 32'hffff_ffff;
    hb_set[3] = 32'd60;         ttl_set[3] = 32'd400;
    hb_set[4] = $urandom_range(1, 800);
    ttl_set[4] = $urandom_range(1, 3000);
    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(rstc_pkg::CFG_HEARTBEAT, hb_set[ph]);
      write_cfg(rstc_pkg::CFG_TTL, ttl_set[ph]);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int k = 0; k < N_RANDOM / 5; k++) send_op(random_op(), 1'b0, '0);
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN) @(posedge clk_i);

    $display("%0d ops sent, %0d results checked under 5 threshold settings", n_items,
             n_checked);
    $display("cache-full drops %0d, takeovers %0d, stale lookups %0d", n_full, n_took,
             n_stale);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the run time of ~1450 items, even with heavy stalls.
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
